// File: rtl/prq_pkg.sv
package prq_pkg;

  // Fixed field widths of the stream payload
  localparam int ID_W  = 8;
  localparam int PRI_W = 6;
  localparam int OCC_W = 7;

  localparam int PRI_TOP = (1 << PRI_W) - 1;

  // Defaults for the top-level parameters
  localparam int QUEUE_DEPTH_DEF  = 64;
  localparam int MAX_PRIORITY_DEF = 63;
  localparam int ID_BITS_DEF      = 8;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  // Operation carried in s_tuser
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  // Which logical slot the memory read port looks at
  typedef enum logic [1:0] {
    RD_HEAD   = 2'd0,  // logical slot 0
    RD_NEXT   = 2'd1,  // logical slot 1
    RD_BELOW  = 2'd2,  // logical slot idx-1
    RD_BELOW2 = 2'd3   // logical slot idx-2
  } rd_sel_t;

  typedef struct packed {
    logic    idle;       // ready for a new transaction
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;      // write at logical slot idx
    logic    wr_shift;   // 1: move the read entry up, 0: write the new entry
    logic    dec_idx;
    logic    place;      // new entry lands, count grows
    logic    pop_take;   // latch head, advance head pointer, count shrinks
    logic    head_load;  // head priority from read data
    logic    out_load;   // load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_accept;
    logic in_kind;
    logic full;
    logic empty;
    logic idx_zero;
    logic idx_one;
    logic shift_needed;  // slot just read ranks below the new entry
    logic out_free;
  } ctrl_sts_t;

endpackage

// File: rtl/prq_ctrl.sv
module prq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  prq_pkg::ctrl_sts_t  sts,
  output prq_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_INS_CHK  = 6'b000010,
    S_INS_CMP  = 6'b000100,
    S_POP_RD   = 6'b001000,
    S_POP_HEAD = 6'b010000,
    S_FINISH   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = prq_pkg::RD_HEAD;
    case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (sts.in_accept) begin
          if (sts.in_kind == prq_pkg::KIND_INSERT) begin
            state_next = sts.full ? S_FINISH : S_INS_CHK;
          end else if (sts.empty) begin
            state_next = S_FINISH;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = prq_pkg::RD_HEAD;
            state_next = S_POP_RD;
          end
        end
      end
      S_INS_CHK: begin
        if (sts.idx_zero) begin
          cmd.wr_en  = 1'b1;
          cmd.place  = 1'b1;
          state_next = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = prq_pkg::RD_BELOW;
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        cmd.wr_en = 1'b1;
        if (sts.shift_needed) begin
          cmd.wr_shift = 1'b1;
          cmd.dec_idx  = 1'b1;
          if (sts.idx_one) begin
            state_next = S_INS_CHK;
          end else begin
            // fetch the next lower slot while this one moves up
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = prq_pkg::RD_BELOW2;
          end
        end else begin
          cmd.place  = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_POP_RD: begin
        cmd.pop_take = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = prq_pkg::RD_NEXT;
        state_next   = S_POP_HEAD;
      end
      S_POP_HEAD: begin
        cmd.head_load = 1'b1;
        state_next    = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/prq_dp.sv
module prq_dp #(
  parameter int QUEUE_DEPTH  = prq_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_PRIORITY = prq_pkg::MAX_PRIORITY_DEF,
  parameter int ID_BITS      = prq_pkg::ID_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  prq_pkg::ctrl_cmd_t                  cmd,
  output prq_pkg::ctrl_sts_t                  sts,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [prq_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [prq_pkg::OUT_TDATA_W-1:0]     m_tdata
);

  localparam int ID_W  = prq_pkg::ID_W;
  localparam int PRI_W = prq_pkg::PRI_W;
  localparam int ENT_W = ID_W + PRI_W;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam logic [ID_W-1:0] ID_MASK =
    (ID_BITS >= ID_W) ? {ID_W{1'b1}} : ID_W'((1 << ID_BITS) - 1);
  localparam logic [PRI_W-1:0] PRI_CAP =
    (MAX_PRIORITY >= prq_pkg::PRI_TOP) ? PRI_W'(prq_pkg::PRI_TOP) : PRI_W'(MAX_PRIORITY);

  // Entry storage, circular around head_ptr, kept in priority order
  logic [ENT_W-1:0] mem [QUEUE_DEPTH];
  logic [ENT_W-1:0] rd_data;

  logic [PTR_W-1:0] head_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [PRI_W-1:0] head_pri;

  logic [ID_W-1:0]  req_id;
  logic [PRI_W-1:0] req_pri;
  logic [PRI_W-1:0] run_pri;
  logic             overflow;
  logic             pop_valid;
  logic [ID_W-1:0]  pop_id;
  logic [PRI_W-1:0] pop_pri;

  logic [ID_W-1:0]  in_id;
  logic [PRI_W-1:0] in_pri;
  logic [PRI_W-1:0] in_run;
  logic [PRI_W-1:0] in_pri_sat;
  logic             accept;

  logic [CNT_W-1:0] rd_off;
  logic [PTR_W-1:0] rd_addr;
  logic [PTR_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic [PRI_W-1:0] rd_pri;
  logic [ID_W-1:0]  rd_id;

  logic             head_valid;
  logic [PRI_W-1:0] head_pri_out;
  logic             preempt;

  // Logical slot to memory address: one compare-subtract for the wrap
  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] base,
                                            input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  assign in_id      = s_tdata[ID_W-1:0] & ID_MASK;
  assign in_pri     = s_tdata[ID_W+PRI_W-1:ID_W];
  assign in_run     = s_tdata[ID_W+2*PRI_W-1:ID_W+PRI_W];
  assign in_pri_sat = (in_pri > PRI_CAP) ? PRI_CAP : in_pri;

  assign s_tready = cmd.idle;
  assign accept   = s_tvalid && s_tready;

  assign rd_pri = rd_data[PRI_W-1:0];
  assign rd_id  = rd_data[ENT_W-1:PRI_W];

  always_comb begin
    case (cmd.rd_sel)
      prq_pkg::RD_HEAD:   rd_off = '0;
      prq_pkg::RD_NEXT:   rd_off = CNT_W'(1);
      prq_pkg::RD_BELOW:  rd_off = idx - CNT_W'(1);
      prq_pkg::RD_BELOW2: rd_off = idx - CNT_W'(2);
      default:            rd_off = '0;
    endcase
  end

  assign rd_addr = phys(head_ptr, rd_off);
  assign wr_addr = phys(head_ptr, idx);
  assign wr_data = cmd.wr_shift ? rd_data : {req_id, req_pri};

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.place) begin
        count <= count + CNT_W'(1);
      end else if (cmd.pop_take) begin
        count    <= count - CNT_W'(1);
        head_ptr <= (head_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ptr + PTR_W'(1);
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_id    <= in_id;
      req_pri   <= in_pri_sat;
      run_pri   <= in_run;
      overflow  <= (s_tuser == prq_pkg::KIND_INSERT) && sts.full;
      pop_valid <= 1'b0;
      pop_id    <= '0;
      pop_pri   <= '0;
      idx       <= count;
    end else if (cmd.dec_idx) begin
      idx <= idx - CNT_W'(1);
    end
    if (cmd.pop_take) begin
      pop_valid <= 1'b1;
      pop_id    <= rd_id;
      pop_pri   <= rd_pri;
    end
    if (cmd.place && idx == '0) begin
      head_pri <= req_pri;
    end else if (cmd.head_load) begin
      head_pri <= rd_pri;
    end
    if (cmd.out_load) begin
      m_tdata <= {1'b0, overflow, prq_pkg::OCC_W'(count), preempt, head_pri_out,
                  head_valid, pop_pri, pop_id, pop_valid};
    end
  end

  assign head_valid   = (count != '0);
  assign head_pri_out = head_valid ? head_pri : '0;
  assign preempt      = head_valid && (head_pri > run_pri);

  assign sts.in_accept    = accept;
  assign sts.in_kind      = s_tuser;
  assign sts.full         = (count == CNT_W'(QUEUE_DEPTH));
  assign sts.empty        = (count == '0);
  assign sts.idx_zero     = (idx == '0);
  assign sts.idx_one      = (idx == CNT_W'(1));
  assign sts.shift_needed = (rd_pri < req_pri);
  assign sts.out_free     = !m_tvalid || m_tready;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_place_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.place |-> !sts.full)
    else $error("entry placed into a full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_take |-> !sts.empty)
    else $error("pop from an empty queue");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result register overwritten while still held");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_shift |-> (idx != '0) && (idx <= count))
    else $error("shift outside the occupied slots");
`endif

endmodule

// File: rtl/priority_ready_queue_unit.sv
// Priority ready queue. Holds up to QUEUE_DEPTH (thread id, priority) entries
// ordered highest priority first, arrival order among equal priorities. A
// transaction on the slave side (s_tuser = 0 insert, 1 pop) yields exactly one
// result transaction on the master side carrying the popped entry (zeros when
// none, meaning run idle), the new head, occupancy, an overflow flag for a
// dropped insert into a full queue, and a preempt flag (head outranks the
// given running priority). One transaction is worked at a time; the next is
// taken as soon as the previous result sits in the output register. An insert
// moves each queued entry of lower priority up one slot (up to QUEUE_DEPTH - 1
// of them) and lands ahead of them; the walk moves one entry per cycle through
// the memory, reading the next slot while writing the current one. A pop steps
// through head read, next-head read, head update and result load; an empty pop
// or a full insert goes straight to the result load. The result load waits
// while the result register still holds an untaken result. Priorities above
// MAX_PRIORITY are saturated; ids keep their low ID_BITS bits. Storage comes
// out of reset uninitialized; popping the last entry reads an unoccupied slot,
// but head_priority is then forced to zero.
module priority_ready_queue_unit #(
  parameter int QUEUE_DEPTH  = prq_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_PRIORITY = prq_pkg::MAX_PRIORITY_DEF,
  parameter int ID_BITS      = prq_pkg::ID_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // s_tdata: thread_id[7:0], priority_req[13:8], running_priority[19:14], zero pad
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [prq_pkg::IN_TDATA_W-1:0]   s_tdata,
  // s_tuser: kind (0 insert, 1 pop)
  input  logic                             s_tuser,
  // m_tdata: popped_valid[0], popped_id[8:1], popped_priority[14:9],
  //          head_valid[15], head_priority[21:16], preempt[22],
  //          occupancy[29:23], overflow[30], zero pad[31]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [prq_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  prq_pkg::ctrl_cmd_t cmd;
  prq_pkg::ctrl_sts_t sts;

  // Sequencer: accept, ordered-insert walk, pop, result hand-off
  prq_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // Entry memory, pointers, counters and result register
  prq_dp #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .MAX_PRIORITY (MAX_PRIORITY),
    .ID_BITS      (ID_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// File: tb/sv/tb_priority_ready_queue_unit.sv
module tb_priority_ready_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ID_W         = prq_pkg::ID_W;
  localparam int PRI_W        = prq_pkg::PRI_W;
  localparam int OCC_W        = prq_pkg::OCC_W;
  localparam int DEPTH        = prq_pkg::QUEUE_DEPTH_DEF;
  localparam int MAX_PRI      = prq_pkg::MAX_PRIORITY_DEF;
  localparam int RANDOM_ITEMS = 1030;
  // Longest correct quiet stretch: an insert walking the whole queue, a sender
  // gap and a long receiver stall. Several times that is still small.
  localparam int QUIET_LIMIT  = 4000;
  // Tail after the last result: a full-depth walk and then some.
  localparam int TAIL_CYCLES  = 2 * DEPTH + 16;

  localparam logic [ID_W-1:0] ID_KEEP = ID_W'((64'd1 << prq_pkg::ID_BITS_DEF) - 1);

  // s_tdata layout, lowest bits last in the list below
  typedef struct packed {
    logic [3:0]       pad;
    logic [PRI_W-1:0] running_priority;
    logic [PRI_W-1:0] priority_req;
    logic [ID_W-1:0]  thread_id;
  } sched_req_t;

  // m_tdata layout
  typedef struct packed {
    logic             pad;
    logic             overflow;
    logic [OCC_W-1:0] occupancy;
    logic             preempt;
    logic [PRI_W-1:0] head_priority;
    logic             head_valid;
    logic [PRI_W-1:0] popped_priority;
    logic [ID_W-1:0]  popped_id;
    logic             popped_valid;
  } sched_rsp_t;

  typedef struct {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } ready_entry_t;

  // Receiver stall styles
  typedef enum logic [1:0] {
    RX_STREAM   = 2'd0,  // always ready
    RX_COIN     = 2'd1,  // ready half the time
    RX_SPARSE   = 2'd2,  // ready with a chance of one in five
    RX_PERIODIC = 2'd3   // periodic, ready three eighths of the time
  } rx_mode_t;

  // ---------------------------------------------------------------------------
  // Scoreboard: keeps its own sorted ready list, predicts one result per
  // accepted request transaction and checks results in order.
  // ---------------------------------------------------------------------------
  class ready_queue_model;
    ready_entry_t sorted_q[$];
    sched_rsp_t   pending_rsp[$];
    int errors, checked;
    int inserts, pops, overflows, idle_pops, preempts, peak_occ;

    function new();
      errors    = 0;
      checked   = 0;
      inserts   = 0;
      pops      = 0;
      overflows = 0;
      idle_pops = 0;
      preempts  = 0;
      peak_occ  = 0;
    endfunction

    function void note_request(logic kind, sched_req_t req);
      sched_rsp_t   rsp;
      ready_entry_t ent;
      int           pos;
      rsp = '0;
      if (kind == prq_pkg::KIND_INSERT) begin
        inserts++;
        if (sorted_q.size() >= DEPTH) begin
          // full queue: entry dropped, state untouched
          rsp.overflow = 1'b1;
          overflows++;
        end else begin
          ent.id  = req.thread_id & ID_KEEP;
          ent.pri = (req.priority_req > MAX_PRI) ? PRI_W'(MAX_PRI) : req.priority_req;
          // land behind every entry of equal or higher priority (FIFO on ties)
          pos = 0;
          while (pos < sorted_q.size() && sorted_q[pos].pri >= ent.pri) pos++;
          sorted_q.insert(pos, ent);
        end
      end else begin
        pops++;
        if (sorted_q.size() > 0) begin
          ent = sorted_q.pop_front();
          rsp.popped_valid    = 1'b1;
          rsp.popped_id       = ent.id;
          rsp.popped_priority = ent.pri;
        end else begin
          idle_pops++;  // nothing to run: idle thread, all popped fields zero
        end
      end
      rsp.occupancy = OCC_W'(sorted_q.size());
      if (sorted_q.size() > 0) begin
        rsp.head_valid    = 1'b1;
        rsp.head_priority = sorted_q[0].pri;
        rsp.preempt       = (sorted_q[0].pri > req.running_priority);
      end
      if (rsp.preempt) preempts++;
      if (sorted_q.size() > peak_occ) peak_occ = sorted_q.size();
      pending_rsp.push_back(rsp);
    endfunction

    function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
        $error("%s: expected %0d, got %0d", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(sched_rsp_t got);
      sched_rsp_t exp_rsp;
      if (pending_rsp.size() == 0) begin
        $error("result transaction with no request outstanding: m_tdata=%h", got);
        errors++;
        return;
      end
      exp_rsp = pending_rsp.pop_front();
      checked++;
      compare_field("popped_valid",    exp_rsp.popped_valid,    got.popped_valid);
      compare_field("popped_id",       exp_rsp.popped_id,       got.popped_id);
      compare_field("popped_priority", exp_rsp.popped_priority, got.popped_priority);
      compare_field("head_valid",      exp_rsp.head_valid,      got.head_valid);
      compare_field("head_priority",   exp_rsp.head_priority,   got.head_priority);
      compare_field("preempt",         exp_rsp.preempt,         got.preempt);
      compare_field("occupancy",       exp_rsp.occupancy,       got.occupancy);
      compare_field("overflow",        exp_rsp.overflow,        got.overflow);
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic                            clk      = 1'b0;
  logic                            rst      = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [prq_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;   // thread_id, priority_req, running_priority, pad
  logic                            s_tuser  = 1'b0; // kind
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [prq_pkg::OUT_TDATA_W-1:0] m_tdata;         // popped_valid .. overflow, pad

  always #6 clk = ~clk;

  priority_ready_queue_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  ready_queue_model model = new();

  // ---------------------------------------------------------------------------
  // Sender: bursts of back-to-back transactions separated by random gaps.
  // tvalid stays high across a burst; it is only dropped at a gap and after the last request.
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic issue_request(logic kind, logic [ID_W-1:0] id,
                               logic [PRI_W-1:0] pri, logic [PRI_W-1:0] run);
    sched_req_t req;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      // mostly short bursts, now and then a long gap-free stretch
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    req = '{pad: '0, running_priority: run, priority_req: pri, thread_id: id};
    s_tuser  <= kind;
    s_tdata  <= req;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall style switches after each randomly sized stretch.
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode = RX_STREAM;
  int       rx_left = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 150);
    end
    rx_left--;
    case (rx_mode)
      RX_STREAM:   m_tready <= 1'b1;
      RX_COIN:     m_tready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE:   m_tready <= ($urandom_range(0, 4) == 0);
      RX_PERIODIC: m_tready <= ((rx_left % 8) < 3);
      default:     m_tready <= 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Monitor: values seen here are the ones present at the clock edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) model.note_request(s_tuser, sched_req_t'(s_tdata));
      if (m_tvalid && m_tready) model.check_result(sched_rsp_t'(m_tdata));
    end
  end

  // Watchdog: too long without any transaction on either side
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("priority_ready_queue_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int seg_left;
    int seg_idx;
    int ins_pct;
    int pri_lo;
    int pri_hi;
    seg_left = 0;
    seg_idx  = 0;
    ins_pct  = 50;
    pri_lo   = 0;
    pri_hi   = 63;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty pops, field extremes, ties at both ends and in the middle
    issue_request(prq_pkg::KIND_POP,    8'hFF, 6'd63, 6'd0);   // empty: idle result
    issue_request(prq_pkg::KIND_POP,    8'h00, 6'd0,  6'd63);
    issue_request(prq_pkg::KIND_INSERT, 8'h00, 6'd0,  6'd0);   // lowest priority, no preempt
    issue_request(prq_pkg::KIND_INSERT, 8'hFF, 6'd63, 6'd62);  // new head, preempts
    issue_request(prq_pkg::KIND_INSERT, 8'hAA, 6'd63, 6'd63);  // tie at top: no preempt
    issue_request(prq_pkg::KIND_INSERT, 8'h55, 6'd0,  6'd63);  // tie at bottom
    issue_request(prq_pkg::KIND_INSERT, 8'h01, 6'd32, 6'd31);
    issue_request(prq_pkg::KIND_INSERT, 8'h10, 6'd20, 6'd0);
    issue_request(prq_pkg::KIND_INSERT, 8'h11, 6'd20, 6'd0);
    issue_request(prq_pkg::KIND_INSERT, 8'h12, 6'd20, 6'd0);
    issue_request(prq_pkg::KIND_INSERT, 8'h13, 6'd21, 6'd0);   // jumps ahead of the 20s
    repeat (10) issue_request(prq_pkg::KIND_POP, 8'h00, 6'd0, 6'd20);
    issue_request(prq_pkg::KIND_POP,    8'h00, 6'd0,  6'd0);   // queue already empty: idle result
    issue_request(prq_pkg::KIND_POP,    8'h00, 6'd0,  6'd0);

    // Random: segments with their own insert/pop mix and priority band.
    // The first fills past full (drops), the second drains past empty.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        case (seg_idx)
          0: begin
            ins_pct = 100; seg_left = DEPTH + 20;
          end
          1: begin
            ins_pct = 0;   seg_left = DEPTH + 10;
          end
          default: begin
            case ($urandom_range(0, 4))
              0: ins_pct = 95;
              1: ins_pct = 70;
              2: ins_pct = 50;
              3: ins_pct = 30;
              default: ins_pct = 5;
            endcase
            seg_left = $urandom_range(20, 120);
          end
        endcase
        // narrow bands give lots of ties; the full band exercises long walks
        case ($urandom_range(0, 3))
          0: begin
            pri_lo = 0;  pri_hi = 3;
          end
          1: begin
            pri_lo = 60; pri_hi = 63;
          end
          2: begin
            pri_lo = 30; pri_hi = 33;
          end
          default: begin
            pri_lo = 0;  pri_hi = 63;
          end
        endcase
        seg_idx++;
      end
      seg_left--;
      if ($urandom_range(1, 100) <= ins_pct)
        issue_request(prq_pkg::KIND_INSERT, ID_W'($urandom_range(0, 255)),
                      PRI_W'($urandom_range(pri_lo, pri_hi)),
                      PRI_W'($urandom_range(0, 63)));
      else
        issue_request(prq_pkg::KIND_POP, ID_W'($urandom_range(0, 255)),
                      PRI_W'($urandom_range(0, 63)),
                      PRI_W'($urandom_range(0, 63)));
    end
    s_tvalid <= 1'b0;

    // Drain: watchdog guards against a result that never shows up
    while (model.pending_rsp.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d inserts (%0d dropped on a full queue), %0d pops (%0d idle)",
             model.inserts, model.overflows, model.pops, model.idle_pops);
    $display("%0d results checked, %0d with preempt set, peak occupancy %0d, %0d mismatches",
             model.checked, model.preempts, model.peak_occ, model.errors);
    if (model.errors == 0 && model.pending_rsp.size() == 0) begin
      $display("priority_ready_queue_unit test passed");
    end else begin
      $display("priority_ready_queue_unit test failed");
    end
    $finish;
  end

endmodule
